// ----- hw/rtl/sha_pkg.sv -----
// sha_pkg: shared types, constants and round functions for the sha-256 stream hasher
// no dependencies
package sha_pkg;

   localparam int unsigned WordBits   = 32;
   localparam int unsigned CountBits  = 61;
   localparam int unsigned PadLimit   = 55;
   localparam logic [7:0]  PadByte    = 8'h80;

   typedef struct packed {
      logic [7:0] message_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       put;        // write put_data at put_pos
      logic [5:0] put_pos;
      logic [7:0] put_data;
      logic       put_len;    // write bit length into words 14 and 15
      logic       load;       // copy hash words into working variables
      logic       round;      // run one round
      logic [5:0] round_idx;
      logic       add;        // fold working variables into hash words
      logic       init;       // restore initial hash values
      logic       count_inc;
      logic       count_clr;
   } sha_cmd_type;

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      case (t)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
      return (v >> s) | (v << (32 - s));
   endfunction

endpackage

// ----- hw/rtl/sha_datapath.sv -----
// sha_datapath: block buffer, message schedule, round logic and hash words
// depends on sha_pkg
module sha_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  sha_pkg::sha_cmd_type cmd,
   input  logic [2:0]           rd_sel,
   output logic [31:0]          rd_word
);

   logic [31:0] hash_ff [8];
   logic [31:0] var_ff  [8];
   logic [31:0] win_ff  [16];
   logic [sha_pkg::CountBits-1:0] count_ff;

   logic [3:0]  t_lo;
   logic [31:0] a2, a15, a7, a16, s0, s1, w_new, w_use;
   logic [31:0] t1, t2, ch, maj, e_sig, a_sig;
   logic [63:0] bits;

   always_comb begin
      t_lo  = cmd.round_idx[3:0];
      a2    = win_ff[t_lo - 4'd2];
      a15   = win_ff[t_lo - 4'd15];
      a7    = win_ff[t_lo - 4'd7];
      a16   = win_ff[t_lo];
      s1    = sha_pkg::rotr(a2, 17) ^ sha_pkg::rotr(a2, 19) ^ (a2 >> 10);
      s0    = sha_pkg::rotr(a15, 7) ^ sha_pkg::rotr(a15, 18) ^ (a15 >> 3);
      w_new = s1 + a7 + s0 + a16;
      w_use = cmd.round_idx[5:4] == 2'd0 ? a16 : w_new;
      e_sig = sha_pkg::rotr(var_ff[4], 6) ^ sha_pkg::rotr(var_ff[4], 11)
              ^ sha_pkg::rotr(var_ff[4], 25);
      ch    = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
      a_sig = sha_pkg::rotr(var_ff[0], 2) ^ sha_pkg::rotr(var_ff[0], 13)
              ^ sha_pkg::rotr(var_ff[0], 22);
      maj   = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
      t1    = var_ff[7] + e_sig + ch + sha_pkg::round_k(cmd.round_idx) + w_use;
      t2    = a_sig + maj;
      bits  = {count_ff, 3'b000};
   end

   assign rd_word = hash_ff[rd_sel];

   // byte insert, big-endian within each word
   always_ff @(posedge clock) begin
      if (cmd.put) begin
         case (cmd.put_pos[1:0])
            2'd0: win_ff[cmd.put_pos[5:2]] <= {cmd.put_data, 24'h0};
            2'd1: win_ff[cmd.put_pos[5:2]][23:16] <= cmd.put_data;
            2'd2: win_ff[cmd.put_pos[5:2]][15:8]  <= cmd.put_data;
            default: win_ff[cmd.put_pos[5:2]][7:0] <= cmd.put_data;
         endcase
      end else if (cmd.put_len) begin
         win_ff[14] <= bits[63:32];
         win_ff[15] <= bits[31:0];
      end else if (cmd.round && cmd.round_idx[5:4] != 2'd0) begin
         win_ff[t_lo] <= w_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < 8; i++) var_ff[i] <= hash_ff[i];
      end else if (cmd.round) begin
         var_ff[7] <= var_ff[6];
         var_ff[6] <= var_ff[5];
         var_ff[5] <= var_ff[4];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[3] <= var_ff[2];
         var_ff[2] <= var_ff[1];
         var_ff[1] <= var_ff[0];
         var_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.init) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= sha_pkg::InitHash[i];
      end else if (cmd.add) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + var_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.count_clr) begin
         count_ff <= '0;
      end else if (cmd.count_inc) begin
         count_ff <= count_ff + 1'b1;
      end
   end

endmodule

// ----- hw/rtl/sha_control.sv -----
// sha_control: sequencer for byte intake, padding, compression and digest output
// depends on sha_pkg
module sha_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sha_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_index,
   output sha_pkg::sha_cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_LOAD  = 7'b0000010,
      ST_ROUND = 7'b0000100,
      ST_ADD   = 7'b0001000,
      ST_PAD   = 7'b0010000,
      ST_LEN   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;    // bytes in block / pad position
   logic [5:0]  rnd_ff, rnd_in;
   logic        final_ff, final_in;  // padding in progress
   logic        len_ff, len_in;      // 0x80 pad byte already written
   logic [2:0]  out_ff, out_in;
   logic        take;

   assign req_stall = state_ff != ST_IDLE;
   assign take      = req_valid && !req_stall;
   assign rsp_valid = state_ff == ST_OUT;
   assign rsp_index = out_ff;

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      rnd_in   = rnd_ff;
      final_in = final_ff;
      len_in   = len_ff;
      out_in   = out_ff;
      cmd      = '0;
      cmd.round_idx = rnd_ff;
      cmd.put_pos   = fill_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.put       = 1'b1;
               cmd.put_data  = req_data.message_byte;
               cmd.count_inc = 1'b1;
               fill_in       = fill_ff + 6'd1;
               final_in      = req_data.last_byte;
               if (fill_ff == 6'd63) begin
                  state_in = ST_LOAD;
               end else if (req_data.last_byte) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // first pad byte is 0x80, then zeros up to the length field
            cmd.put      = 1'b1;
            cmd.put_data = len_ff ? 8'h00 : sha_pkg::PadByte;
            len_in       = 1'b1;
            fill_in      = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               state_in = ST_LOAD;
               final_in = 1'b1;
            end else if (fill_ff == 6'(sha_pkg::PadLimit)) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            cmd.put_len = 1'b1;
            fill_in     = '0;
            len_in      = 1'b0;
            final_in    = 1'b0;
            state_in    = ST_LOAD;
            out_in      = 3'd7;     // marks a length block
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            rnd_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add = 1'b1;
            if (out_ff == 3'd7) begin
               out_in   = '0;
               state_in = ST_OUT;
            end else if (final_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               out_in = out_ff + 3'd1;
               if (out_ff == 3'd7) begin
                  cmd.init      = 1'b1;
                  cmd.count_clr = 1'b1;
                  fill_in       = '0;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         rnd_ff   <= '0;
         final_ff <= 1'b0;
         len_ff   <= 1'b0;
         out_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         rnd_ff   <= rnd_in;
         final_ff <= final_in;
         len_ff   <= len_in;
         out_ff   <= out_in;
      end
   end

   a_round_follows_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_ROUND && rnd_ff == 6'd0)
      else $error("round did not start after load");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> !take)
      else $error("byte taken during rounds");
   a_add_after_last_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == 6'd63) |=> cmd.add)
      else $error("missing final addition");
   a_digest_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_index == 3'd0)
      else $error("digest does not start at word zero");

endmodule

// ----- hw/rtl/sha256_stream_hasher.sv -----
// sha256_stream_hasher: top level of the streaming sha-256 hasher
// depends on sha_pkg, sha_control and sha_datapath
//
// Takes one message byte per word; each full 64-byte block then costs one load,
// 64 rounds on a single shared round unit and one addition, during which no
// byte is taken. On the final byte the block pads (one pad byte at a time,
// then the length field), runs one or two more compressions, and then offers
// the eight digest words in order, index 0 first, last_word high on the eighth.
// No byte is taken until the digest has been fully delivered. Empty messages
// cannot be expressed; bit length wraps modulo 2^64.
module sha256_stream_hasher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sha_pkg::rsp_type rsp_data
);

   sha_pkg::sha_cmd_type cmd;     // controller to datapath commands
   logic [2:0]           rd_sel;  // digest word being offered
   logic [31:0]          rd_word;

   sha_control u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_index (rd_sel),
      .cmd       (cmd)
   );

   sha_datapath u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_sel  (rd_sel),
      .rd_word (rd_word)
   );

   // digest words come straight from the hash registers, held while stalled
   assign rsp_data.digest_word = rd_word;
   assign rsp_data.word_index  = rd_sel;
   assign rsp_data.last_word   = rd_sel == 3'd7;

endmodule

// ----- tb/sha256_stream_checker.sv -----
// sha256_stream_checker: watches the byte and digest channels of the hasher,
// predicts each digest with its own sha-256 model and counts mismatches
// depends on sha_pkg
module sha256_stream_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  sha_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  sha_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending_count,
   output int               digest_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] KTab [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] HInit [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   logic [31:0]      hash_state [8];
   logic [31:0]      block_words [16];
   logic [60:0]      byte_total;
   logic [5:0]       fill_pos;
   sha_pkg::rsp_type expected_words [$];

   function automatic logic [31:0] ror(input logic [31:0] v, input int s);
      return (v >> s) | (v << (32 - s));
   endfunction

   task automatic place_byte(input logic [5:0] pos, input logic [7:0] b);
      if (pos[1:0] == 2'd0) block_words[pos[5:2]] = '0;
      block_words[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = b;
   endtask

   task automatic compress();
      logic [31:0] v [8];
      logic [31:0] w, t1, t2, a2, a15;
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int t = 0; t < 64; t++) begin
         if (t < 16) begin
            w = block_words[t];
         end else begin
            a2  = block_words[(t - 2) & 15];
            a15 = block_words[(t - 15) & 15];
            w = (ror(a2, 17) ^ ror(a2, 19) ^ (a2 >> 10)) + block_words[(t - 7) & 15]
                + (ror(a15, 7) ^ ror(a15, 18) ^ (a15 >> 3)) + block_words[t & 15];
            block_words[t & 15] = w;
         end
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[t] + w;
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int i = 7; i > 0; i--) v[i] = v[i - 1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endtask

   task automatic absorb_byte(input sha_pkg::req_type r);
      sha_pkg::rsp_type e;
      int               p;
      logic [63:0]      bits;
      place_byte(fill_pos, r.message_byte);
      byte_total++;
      fill_pos++;
      if (fill_pos == 6'd0) compress();
      if (r.last_byte) begin
         p = fill_pos;
         place_byte(6'(p), sha_pkg::PadByte);
         p++;
         if (p > sha_pkg::PadLimit + 1) begin
            for (; p < 64; p++) place_byte(6'(p), 8'h00);
            compress();
            p = 0;
         end
         for (; p < 56; p++) place_byte(6'(p), 8'h00);
         bits = {byte_total, 3'b000};
         block_words[14] = bits[63:32];
         block_words[15] = bits[31:0];
         compress();
         for (int i = 0; i < 8; i++) begin
            e.digest_word = hash_state[i];
            e.word_index  = 3'(i);
            e.last_word   = (i == 7);
            expected_words.push_back(e);
         end
         for (int i = 0; i < 8; i++) hash_state[i] = HInit[i];
         byte_total = '0;
         fill_pos = '0;
      end
   endtask

   always @(posedge clock) begin
      sha_pkg::rsp_type e;
      int               errs;
      errs = 0;
      if (reset) begin
         for (int i = 0; i < 8; i++) hash_state[i] = HInit[i];
         byte_total = '0;
         fill_pos = '0;
         expected_words.delete();
         error_count <= 0;
         digest_count <= 0;
      end else begin
         if (req_valid && !req_stall) absorb_byte(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%t unexpected digest word: actual %h", $time, rsp_data);
               errs++;
            end else begin
               e = expected_words.pop_front();
               if (rsp_data.word_index == 3'd7) digest_count <= digest_count + 1;
               if (rsp_data.digest_word !== e.digest_word) begin
                  $display("%t digest_word mismatch: expected %h actual %h",
                           $time, e.digest_word, rsp_data.digest_word);
                  errs++;
               end
               if (rsp_data.word_index !== e.word_index) begin
                  $display("%t word_index mismatch: expected %0d actual %0d",
                           $time, e.word_index, rsp_data.word_index);
                  errs++;
               end
               if (rsp_data.last_word !== e.last_word) begin
                  $display("%t last_word mismatch: expected %b actual %b",
                           $time, e.last_word, rsp_data.last_word);
                  errs++;
               end
            end
         end
         error_count <= error_count + errs;
      end
   end

   assign pending_count = expected_words.size();
endmodule

// ----- tb/sha256_stream_hasher_test.sv -----
// sha256_stream_hasher_test: stimulus, clock, reset and verdict for the hasher
// depends on sha_pkg, sha256_stream_hasher and sha256_stream_checker
module sha256_stream_hasher_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit = 20000;   // idle cycles before giving up

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   sha_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   sha_pkg::rsp_type rsp_data;
   int               error_count;
   int               pending_count;
   int               digest_count;
   int               idle_cycles;
   int               byte_words;
   bit               hold_sink;      // forces a long receiver hold-off
   bit               stimulus_done;

   sha256_stream_hasher u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   sha256_stream_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .digest_count  (digest_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // half the time no gap, otherwise mostly short gaps and now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // offer one byte word and wait for it to be taken, after a random gap
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{message_byte: b, last_byte: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      byte_words++;
   endtask

   // a whole message; mode picks the byte content
   task automatic send_message(input int len, input int mode);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         case (mode)
            0: b = 8'h00;
            1: b = 8'hff;
            2: b = 8'(i);
            default: b = 8'($urandom);
         endcase
         send_byte(b, i == len - 1);
      end
   endtask

   task automatic drain();
      while (pending_count != 0) @(posedge clock);
   endtask

   // receiver: random stall, with a forced hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_sink) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 30);
      end
   end

   // holds the receiver off for a long counted stretch once more than 40 byte words are sent
   initial begin
      int held;
      hold_sink = 1'b0;
      wait (byte_words > 40);
      hold_sink = 1'b1;
      held = 0;
      while (held < 1500) begin
         @(posedge clock);
         held++;
      end
      hold_sink = 1'b0;
   end

   // watchdog on cycles with nothing accepted
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > StallLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int len;
      int r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      byte_words = 0;
      stimulus_done = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single bytes at both extremes, then padding boundaries
      send_message(1, 0);
      send_message(1, 1);
      send_message(3, 2);
      send_message(55, 3);   // 0x80 and length fit one block
      send_message(56, 1);   // 0x80 at byte 56 forces an extra block
      send_message(64, 2);   // exactly one full block
      // sender waits until every digest word is out
      req_valid <= 1'b0;
      drain();
      repeat (20) @(posedge clock);

      // random messages, mostly short, a few spanning several blocks
      while (byte_words < 350) begin
         r = $urandom_range(0, 99);
         if (r < 70) len = $urandom_range(1, 12);
         else if (r < 90) len = $urandom_range(50, 70);
         else len = $urandom_range(100, 200);
         if (len > 350 - byte_words) len = 350 - byte_words;
         send_message(len, (r % 7 == 0) ? 2 : 3);
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
      drain();
      repeat (200) @(posedge clock);
      $display("covered %0d byte words and %0d digests, with padding edges and back-pressure",
               byte_words, digest_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
